/* design/ljsp_pkg.sv */
// Package for the look-ahead junction speed planner.
// Holds the field widths, operation and status codes and the saturating add.
// No dependencies.
package ljsp_pkg;

  localparam int SPD_W = 24;  // Q16.8 speed
  localparam int SQ_W  = 48;  // Q32.16 squared speed
  localparam int OFF_W = 4;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int FREE_W = 4;

  typedef logic [SQ_W-1:0]  sq_t;
  typedef logic [SPD_W-1:0] spd_t;

  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_DISCARD = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLAN  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam logic [ST_W-1:0] STAT_OK          = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL        = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY       = 2'd2;
  localparam logic [ST_W-1:0] STAT_BEYOND_HEAD = 2'd3;

  // Sum of two squared speeds, clipped at the largest value.
  function automatic sq_t sat_add(input sq_t a, input sq_t b);
    logic [SQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SQ_W] ? '1 : s[SQ_W-1:0];
  endfunction

endpackage

/* design/lookahead_junction_speed_planner.sv */
// Top level of the look-ahead junction speed planner: segment ring, stores,
// sequencer and the shared saturating adder.
// Depends on ljsp_pkg.
//
//   port group  | direction | handshake            | carries
//   in_*        | input     | in_valid / in_ready  | opcode, speeds, budget, offset
//   out_*       | output    | out_valid / out_ready| status, refresh flag, free slots, speeds
//
// In a push or a replan the reverse and forward passes each walk at most RING_DEPTH-2
// entries, one a cycle through the shared adder.
// Reset clears the ring pointers and the last nominal speed; the stores hold junk.
// A finished beat waits in the output register while the next item is taken, and the
// sequencer holds before its last step if that register is still full.
module lookahead_junction_speed_planner
  import ljsp_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [SPD_W-1:0]  in_nominal_speed,
  input  logic [SQ_W-1:0]   in_junction_limit_sqr,
  input  logic [SQ_W-1:0]   in_decel_budget,
  input  logic [OFF_W-1:0]  in_slot_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic              out_tail_update,
  output logic [FREE_W-1:0] out_free_slots,
  output logic [SQ_W-1:0]   out_exit_speed_sqr,
  output logic [SQ_W-1:0]   out_read_speed_sqr
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_PUSH     = 4'd2;
  localparam logic [3:0] S_PUSH2    = 4'd3;
  localparam logic [3:0] S_RV_BEGIN = 4'd4;
  localparam logic [3:0] S_RV_FIRST = 4'd5;
  localparam logic [3:0] S_RV_STEP  = 4'd6;
  localparam logic [3:0] S_FW_INIT  = 4'd7;
  localparam logic [3:0] S_FW_LD    = 4'd8;
  localparam logic [3:0] S_FW_STEP  = 4'd9;
  localparam logic [3:0] S_RD_CAP   = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;
  localparam logic [3:0] S_FIN2     = 4'd12;

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  function automatic idx_t ring_next(input idx_t i);
    return (i == IW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t ring_prev(input idx_t i);
    return (i == '0) ? IW'(RING_DEPTH - 1) : i - 1'b1;
  endfunction

  // Stores
  sq_t spd_mem_r [RING_DEPTH];
  sq_t lim_mem_r [RING_DEPTH];
  sq_t bud_mem_r [RING_DEPTH];
  sq_t spd_q_r, lim_q_r, bud_q_r;

  // Control state
  logic [3:0] state_r, state_nxt;
  idx_t       head_r, head_nxt;
  idx_t       tail_r, tail_nxt;
  idx_t       planned_r, planned_nxt;
  spd_t       last_nom_r, last_nom_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Working registers
  logic [OP_W-1:0]   op_r, op_nxt;
  spd_t              nom_r, nom_nxt;
  sq_t               jlim_r, jlim_nxt;
  sq_t               bud_r, bud_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  spd_t              m_r, m_nxt;
  sq_t               sq_r, sq_nxt;
  idx_t              cur_r, cur_nxt;
  idx_t              idx_r, idx_nxt;
  sq_t               spdn_r, spdn_nxt;
  sq_t               spdc_r, spdc_nxt;
  sq_t               budc_r, budc_nxt;
  logic              upd_r, upd_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  sq_t               rd_r, rd_nxt;

  // Result register
  logic [ST_W-1:0]   o_status_r, o_status_nxt;
  logic              o_upd_r, o_upd_nxt;
  logic [FREE_W-1:0] o_free_r, o_free_nxt;
  sq_t               o_exit_r, o_exit_nxt;
  sq_t               o_read_r, o_read_nxt;

  // Store ports
  idx_t rd_addr;
  logic spd_we, push_we;
  idx_t spd_waddr;
  sq_t  spd_wdata;

  // Shared saturating adder
  sq_t add_a, add_b, add_sum;

  cnt_t cnt, fr_full, slot_sum;
  idx_t nx, idx2, idxn;
  logic raise, hit_lim;
  sq_t  rv_new;

  assign add_sum = sat_add(add_a, add_b);

  always_comb begin
    if (head_r >= tail_r) begin
      cnt = CW'(head_r) - CW'(tail_r);
    end else begin
      cnt = CW'(head_r) + CW'(RING_DEPTH) - CW'(tail_r);
    end
    fr_full  = CW'(RING_DEPTH - 1) - cnt;
    slot_sum = CW'(tail_r) + CW'(off_r);
    if (slot_sum >= CW'(RING_DEPTH)) begin
      slot_sum = slot_sum - CW'(RING_DEPTH);
    end
    nx = ring_next(tail_r);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    planned_nxt   = planned_r;
    last_nom_nxt  = last_nom_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    nom_nxt       = nom_r;
    jlim_nxt      = jlim_r;
    bud_nxt       = bud_r;
    off_nxt       = off_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    spdn_nxt      = spdn_r;
    spdc_nxt      = spdc_r;
    budc_nxt      = budc_r;
    upd_nxt       = upd_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    o_status_nxt  = o_status_r;
    o_upd_nxt     = o_upd_r;
    o_free_nxt    = o_free_r;
    o_exit_nxt    = o_exit_r;
    o_read_nxt    = o_read_r;
    rd_addr       = idx_r;
    spd_we        = 1'b0;
    push_we       = 1'b0;
    spd_waddr     = cur_r;
    spd_wdata     = '0;
    idx2          = ring_prev(cur_r);
    idxn          = ring_prev(idx2);
    raise         = 1'b0;
    hit_lim       = 1'b0;
    rv_new        = '0;

    if (state_r == S_FW_STEP) begin
      add_a = spdc_r;
      add_b = budc_r;
    end else begin
      add_a = spdn_r;
      add_b = bud_q_r;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          nom_nxt   = in_nominal_speed;
          jlim_nxt  = in_junction_limit_sqr;
          bud_nxt   = in_decel_budget;
          off_nxt   = in_slot_offset;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        status_nxt = STAT_OK;
        upd_nxt    = 1'b0;
        rd_nxt     = '0;
        state_nxt  = S_FIN;
        unique case (op_r)
          OP_PUSH: begin
            if (ring_next(head_r) == tail_r) begin
              status_nxt = STAT_FULL;
            end else begin
              m_nxt     = (nom_r < last_nom_r) ? nom_r : last_nom_r;
              state_nxt = S_PUSH;
            end
          end
          OP_DISCARD: begin
            if (head_r == tail_r) begin
              status_nxt = STAT_EMPTY;
            end else begin
              if (tail_r == planned_r) begin
                planned_nxt = nx;
              end
              tail_nxt = nx;
            end
          end
          OP_REPLAN: begin
            upd_nxt     = 1'b1;
            planned_nxt = tail_r;
            if (head_r != tail_r) begin
              state_nxt = S_RV_BEGIN;
            end
          end
          default: begin
            if (CW'(off_r) >= cnt) begin
              status_nxt = STAT_BEYOND_HEAD;
            end else begin
              rd_addr   = slot_sum[IW-1:0];
              state_nxt = S_RD_CAP;
            end
          end
        endcase
      end

      S_PUSH: begin
        sq_nxt    = {{(SQ_W-SPD_W){1'b0}}, m_r} * {{(SQ_W-SPD_W){1'b0}}, m_r};
        state_nxt = S_PUSH2;
      end

      S_PUSH2: begin
        // An empty ring means the new segment starts from rest.
        if (head_r == tail_r) begin
          jlim_nxt = '0;
          sq_nxt   = '0;
        end else if (sq_r > jlim_r) begin
          sq_nxt = jlim_r;
        end
        push_we      = 1'b1;
        spd_we       = 1'b1;
        spd_waddr    = head_r;
        spd_wdata    = '0;
        last_nom_nxt = nom_r;
        head_nxt     = ring_next(head_r);
        state_nxt    = S_RV_BEGIN;
      end

      S_RV_BEGIN: begin
        if (ring_prev(head_r) == planned_r) begin
          state_nxt = S_FIN;
        end else begin
          cur_nxt   = ring_prev(head_r);
          rd_addr   = ring_prev(head_r);
          state_nxt = S_RV_FIRST;
        end
      end

      S_RV_FIRST: begin
        // The newest segment must be able to stop within its own budget.
        rv_new    = (lim_q_r < bud_q_r) ? lim_q_r : bud_q_r;
        spd_we    = 1'b1;
        spd_waddr = cur_r;
        spd_wdata = rv_new;
        spdn_nxt  = rv_new;
        if (idx2 == planned_r) begin
          if (idx2 == tail_r) begin
            upd_nxt = 1'b1;
          end
          state_nxt = S_FW_INIT;
        end else begin
          if (idxn == tail_r) begin
            upd_nxt = 1'b1;
          end
          cur_nxt   = idx2;
          rd_addr   = idx2;
          idx_nxt   = idxn;
          state_nxt = S_RV_STEP;
        end
      end

      S_RV_STEP: begin
        if (spd_q_r != lim_q_r) begin
          rv_new    = (add_sum < lim_q_r) ? add_sum : lim_q_r;
          spd_we    = 1'b1;
          spd_waddr = cur_r;
          spd_wdata = rv_new;
          spdn_nxt  = rv_new;
        end else begin
          spdn_nxt = spd_q_r;
        end
        if (idx_r == planned_r) begin
          state_nxt = S_FW_INIT;
        end else begin
          if (ring_prev(idx_r) == tail_r) begin
            upd_nxt = 1'b1;
          end
          cur_nxt = idx_r;
          rd_addr = idx_r;
          idx_nxt = ring_prev(idx_r);
        end
      end

      S_FW_INIT: begin
        if (ring_next(planned_r) == head_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_addr   = planned_r;
          idx_nxt   = ring_next(planned_r);
          state_nxt = S_FW_LD;
        end
      end

      S_FW_LD: begin
        spdc_nxt  = spd_q_r;
        budc_nxt  = bud_q_r;
        rd_addr   = idx_r;
        state_nxt = S_FW_STEP;
      end

      S_FW_STEP: begin
        raise   = (spdc_r < spd_q_r) && (add_sum < spd_q_r);
        hit_lim = raise ? (add_sum == lim_q_r) : (spd_q_r == lim_q_r);
        if (raise) begin
          spd_we    = 1'b1;
          spd_waddr = idx_r;
          spd_wdata = add_sum;
        end
        if (raise || hit_lim) begin
          planned_nxt = idx_r;
        end
        spdc_nxt = raise ? add_sum : spd_q_r;
        budc_nxt = bud_q_r;
        idx_nxt  = ring_next(idx_r);
        rd_addr  = ring_next(idx_r);
        if (ring_next(idx_r) == head_r) begin
          state_nxt = S_FIN;
        end
      end

      S_RD_CAP: begin
        rd_nxt    = spd_q_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        rd_addr   = nx;
        state_nxt = S_FIN2;
      end

      S_FIN2: begin
        rd_addr = nx;
        if (!out_valid_r || out_ready) begin
          o_status_nxt  = status_r;
          o_upd_nxt     = upd_r;
          o_free_nxt    = (fr_full > CW'(15)) ? 4'hF : fr_full[FREE_W-1:0];
          o_exit_nxt    = (nx == head_r) ? '0 : spd_q_r;
          o_read_nxt    = rd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Stores: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (spd_we) begin
      spd_mem_r[spd_waddr] <= spd_wdata;
    end
    spd_q_r <= spd_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      lim_mem_r[head_r] <= sq_nxt;
      bud_mem_r[head_r] <= bud_r;
    end
    lim_q_r <= lim_mem_r[rd_addr];
    bud_q_r <= bud_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      planned_r   <= '0;
      last_nom_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      planned_r   <= planned_nxt;
      last_nom_r  <= last_nom_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    nom_r      <= nom_nxt;
    jlim_r     <= jlim_nxt;
    bud_r      <= bud_nxt;
    off_r      <= off_nxt;
    m_r        <= m_nxt;
    sq_r       <= sq_nxt;
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    spdn_r     <= spdn_nxt;
    spdc_r     <= spdc_nxt;
    budc_r     <= budc_nxt;
    upd_r      <= upd_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    o_status_r <= o_status_nxt;
    o_upd_r    <= o_upd_nxt;
    o_free_r   <= o_free_nxt;
    o_exit_r   <= o_exit_nxt;
    o_read_r   <= o_read_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_tail_update    = o_upd_r;
  assign out_free_slots     = o_free_r;
  assign out_exit_speed_sqr = o_exit_r;
  assign out_read_speed_sqr = o_read_r;

endmodule
